// ===== hdl/perspective_point_projection_core_macros.svh =====
// Assertion macros for the projection core. Each expects clk and rst_n in scope.
`ifndef PERSPECTIVE_POINT_PROJECTION_CORE_MACROS_SVH
`define PERSPECTIVE_POINT_PROJECTION_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PPP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// next-cycle implication
`define PPP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PPP_ASSERT_IMP(lbl, ante, cons)
`define PPP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/ppp_pkg.sv =====
package ppp_pkg;

    localparam int unsigned VAL_W = 32;
    localparam int unsigned DEN_W = 31;
    localparam int unsigned WIDE_W = 66;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    localparam logic [7:0] REG_WINDOW_WIDTH  = 8'd0;
    localparam logic [7:0] REG_WINDOW_HEIGHT = 8'd1;

    localparam logic [15:0] WINDOW_WIDTH_RESET  = 16'd1920;
    localparam logic [15:0] WINDOW_HEIGHT_RESET = 16'd1080;

    // pipeline sideband that travels with each item
    typedef struct packed {
        logic valid;
        logic visible;
        logic neg_x;
        logic neg_y;
    } side_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        begin
            hi = WIDE_W'(32'sh7FFF_FFFF);
            lo = -(WIDE_W'(64'sh8000_0000));
            if (v > hi)
                sat32 = 32'sh7FFF_FFFF;
            else if (v < lo)
                sat32 = 32'sh8000_0000;
            else
                sat32 = v[VAL_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/perspective_point_projection_core.sv =====
// From input accept to result each item passes the clip, divider and viewport stages.
// Throughput: one item per cycle; the whole pipeline advances when the output is free.
// The divider costs one stage per quotient bit (32 + FRAC_BITS stages).
// Reset (rst_n low, async): pipeline empty, matrix all zero, window 1920 x 1080.
// Load items write the matrix at accept and leave a bubble; no result.
`include "perspective_point_projection_core_macros.svh"

module perspective_point_projection_core #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: entry_index[3:0], entry_value[35:4], pos_x[67:36], pos_y[99:68],
    //        pos_z[131:100], zero pad[135:132]
    input  logic [135:0] s_tdata,
    // tuser: operation[0]
    input  logic         s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: screen_x[31:0], screen_y[63:32]
    output logic [63:0]  m_tdata,
    // tuser: visible[0]
    output logic         m_tuser,
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int unsigned NUM_W = 32 + FRAC_BITS;

    logic [15:0] win_w_reg, win_h_reg;
    logic        en;
    logic        s_accept;

    ppp_pkg::side_t              clip_side, div_side;
    logic [NUM_W-1:0]            num_x, num_y, q_x, q_y;
    logic [ppp_pkg::DEN_W-1:0]   den;
    logic signed [31:0]          screen_x, screen_y;

    // Single global advance: a stall freezes every stage, bubbles included.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_w_reg <= ppp_pkg::WINDOW_WIDTH_RESET;
            win_h_reg <= ppp_pkg::WINDOW_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ppp_pkg::REG_WINDOW_WIDTH:  win_w_reg <= cfg_data;
                ppp_pkg::REG_WINDOW_HEIGHT: win_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Matrix products, clip sums, visibility test.
    ppp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .load_we     (s_accept && (s_tuser == ppp_pkg::OP_LOAD)),
        .proj_in     (s_accept && (s_tuser == ppp_pkg::OP_PROJECT)),
        .entry_index (s_tdata[3:0]),
        .entry_value (s_tdata[35:4]),
        .pos_x       (s_tdata[67:36]),
        .pos_y       (s_tdata[99:68]),
        .pos_z       (s_tdata[131:100]),
        .side        (clip_side),
        .num_x       (num_x),
        .num_y       (num_y),
        .den         (den)
    );

    // Perspective divide, both lanes by clip w.
    ppp_divider #(.NUM_W(NUM_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .side_in  (clip_side),
        .num_a    (num_x),
        .num_b    (num_y),
        .den_in   (den),
        .side_out (div_side),
        .q_a      (q_x),
        .q_b      (q_y)
    );

    // Viewport mapping; its last stage is the output register.
    ppp_viewport #(.FRAC_BITS(FRAC_BITS)) u_vp (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .side_in     (div_side),
        .q_x         (q_x),
        .q_y         (q_y),
        .half_w      (win_w_reg[15:1]),
        .half_h      (win_h_reg[15:1]),
        .out_valid   (m_tvalid),
        .out_visible (m_tuser),
        .screen_x    (screen_x),
        .screen_y    (screen_y)
    );

    assign m_tdata = {screen_y, screen_x};

    // Hidden points carry zero coordinates.
    `PPP_ASSERT_IMP(a_hidden_zero, m_tvalid && !m_tuser, m_tdata == 64'd0)
    // A stalled result holds its value and flag.
    `PPP_ASSERT_NXT(a_stall_data, m_tvalid && !m_tready, $stable(m_tdata) && m_tvalid)
    `PPP_ASSERT_NXT(a_stall_user, m_tvalid && !m_tready, $stable(m_tuser))

endmodule

// ===== hdl/ppp_clip.sv =====
module ppp_clip #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   load_we,
    input  logic                   proj_in,
    input  logic [3:0]             entry_index,
    input  logic signed [31:0]     entry_value,
    input  logic signed [31:0]     pos_x,
    input  logic signed [31:0]     pos_y,
    input  logic signed [31:0]     pos_z,
    output ppp_pkg::side_t         side,
    output logic [32+FRAC_BITS-1:0] num_x,
    output logic [32+FRAC_BITS-1:0] num_y,
    output logic [ppp_pkg::DEN_W-1:0] den
);

    localparam int unsigned NUM_W = 32 + FRAC_BITS;
    localparam int THR = ((1 << FRAC_BITS) + 5) / 10;
    localparam int unsigned W = ppp_pkg::WIDE_W;

    logic signed [31:0] mat_reg [16];
    logic signed [63:0] prod_reg [9];
    logic signed [31:0] trans_reg [3];
    logic               v1_reg;
    logic signed [31:0] clip_reg [3];
    logic               v2_reg;
    ppp_pkg::side_t     side_reg;
    logic [NUM_W-1:0]   num_x_reg;
    logic [NUM_W-1:0]   num_y_reg;
    logic [ppp_pkg::DEN_W-1:0] den_reg;

    logic signed [31:0] pos [3];
    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= '0;
        end
        else if (load_we)
        begin
            mat_reg[entry_index] <= entry_value;
        end
    end

    // stage 1: exact products of rows 0, 1 and 3
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                    prod_reg[r*3+c] <= 64'(pos[c]) * 64'(mat_reg[((r == 2) ? 3 : r)*4 + c]);
                trans_reg[r] <= mat_reg[((r == 2) ? 3 : r)*4 + 3];
            end
        end
    end

    // stage 2: floor shift, sum with translation, saturate
    logic signed [W-1:0] sum [3];
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum[r] = W'(trans_reg[r]);
            for (int c = 0; c < 3; c++)
                sum[r] = sum[r] + W'(prod_reg[r*3+c] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                clip_reg[r] <= ppp_pkg::sat32(sum[r]);
        end
    end

    // stage 3: visibility test and magnitudes for the divider
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    assign mag_x = clip_reg[0][31] ? 32'(-clip_reg[0]) : 32'(clip_reg[0]);
    assign mag_y = clip_reg[1][31] ? 32'(-clip_reg[1]) : 32'(clip_reg[1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_x_reg <= {mag_x, {FRAC_BITS{1'b0}}};
            num_y_reg <= {mag_y, {FRAC_BITS{1'b0}}};
            den_reg   <= clip_reg[2][ppp_pkg::DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            side_reg <= '0;
        end
        else if (en)
        begin
            v1_reg           <= proj_in;
            v2_reg           <= v1_reg;
            side_reg.valid   <= v2_reg;
            side_reg.visible <= (clip_reg[2] >= 32'(THR));
            side_reg.neg_x   <= clip_reg[0][31];
            side_reg.neg_y   <= clip_reg[1][31];
        end
    end

    assign side  = side_reg;
    assign num_x = num_x_reg;
    assign num_y = num_y_reg;
    assign den   = den_reg;

endmodule

// ===== hdl/ppp_divider.sv =====
// Two-lane restoring divider, one quotient bit per stage, shared divisor.
module ppp_divider #(
    parameter int unsigned NUM_W = 48
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  ppp_pkg::side_t            side_in,
    input  logic [NUM_W-1:0]          num_a,
    input  logic [NUM_W-1:0]          num_b,
    input  logic [ppp_pkg::DEN_W-1:0] den_in,
    output ppp_pkg::side_t            side_out,
    output logic [NUM_W-1:0]          q_a,
    output logic [NUM_W-1:0]          q_b
);

    localparam int unsigned DW = ppp_pkg::DEN_W;

    // nq: numerator bits shift out the top, quotient bits shift in the bottom
    logic [DW-1:0]    rem_a_reg [NUM_W];
    logic [DW-1:0]    rem_b_reg [NUM_W];
    logic [NUM_W-1:0] nq_a_reg  [NUM_W];
    logic [NUM_W-1:0] nq_b_reg  [NUM_W];
    logic [DW-1:0]    den_reg   [NUM_W];
    ppp_pkg::side_t   side_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic [DW-1:0]    rem_a_in, rem_b_in, den_k;
        logic [NUM_W-1:0] nq_a_in, nq_b_in;
        ppp_pkg::side_t   side_k;
        logic [DW:0]      trial_a, trial_b, diff_a, diff_b;
        logic             ge_a, ge_b;

        if (k == 0)
        begin : g_first
            assign rem_a_in = '0;
            assign rem_b_in = '0;
            assign nq_a_in  = num_a;
            assign nq_b_in  = num_b;
            assign den_k    = den_in;
            assign side_k   = side_in;
        end
        else
        begin : g_next
            assign rem_a_in = rem_a_reg[k-1];
            assign rem_b_in = rem_b_reg[k-1];
            assign nq_a_in  = nq_a_reg[k-1];
            assign nq_b_in  = nq_b_reg[k-1];
            assign den_k    = den_reg[k-1];
            assign side_k   = side_reg[k-1];
        end

        assign trial_a = {rem_a_in, nq_a_in[NUM_W-1]};
        assign trial_b = {rem_b_in, nq_b_in[NUM_W-1]};
        assign ge_a    = trial_a >= {1'b0, den_k};
        assign ge_b    = trial_b >= {1'b0, den_k};
        assign diff_a  = trial_a - {1'b0, den_k};
        assign diff_b  = trial_b - {1'b0, den_k};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_a_reg[k] <= ge_a ? diff_a[DW-1:0] : trial_a[DW-1:0];
                rem_b_reg[k] <= ge_b ? diff_b[DW-1:0] : trial_b[DW-1:0];
                nq_a_reg[k]  <= {nq_a_in[NUM_W-2:0], ge_a};
                nq_b_reg[k]  <= {nq_b_in[NUM_W-2:0], ge_b};
                den_reg[k]   <= den_k;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg[k] <= '0;
            else if (en)
                side_reg[k] <= side_k;
        end
    end

    assign side_out = side_reg[NUM_W-1];
    assign q_a      = nq_a_reg[NUM_W-1];
    assign q_b      = nq_b_reg[NUM_W-1];

endmodule

// ===== hdl/ppp_viewport.sv =====
module ppp_viewport #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  ppp_pkg::side_t          side_in,
    input  logic [32+FRAC_BITS-1:0] q_x,
    input  logic [32+FRAC_BITS-1:0] q_y,
    input  logic [14:0]             half_w,
    input  logic [14:0]             half_h,
    output logic                    out_valid,
    output logic                    out_visible,
    output logic signed [31:0]      screen_x,
    output logic signed [31:0]      screen_y
);

    localparam int unsigned W = ppp_pkg::WIDE_W;

    ppp_pkg::side_t     s1_reg, s2_reg;
    logic signed [31:0] ndc_x_reg, ndc_y_reg, ndc_x2_reg, ndc_y2_reg;
    logic signed [47:0] px_reg, py_reg;
    logic [14:0]        hw_reg, hh_reg;
    logic               valid_reg, visible_reg;
    logic signed [31:0] sx_reg, sy_reg;

    // P1: sign and saturate the quotients
    logic signed [W-1:0] wx, wy;
    assign wx = side_in.neg_x ? -$signed(W'(q_x)) : $signed(W'(q_x));
    assign wy = side_in.neg_y ? -$signed(W'(q_y)) : $signed(W'(q_y));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ndc_x_reg <= ppp_pkg::sat32(wx);
            ndc_y_reg <= ppp_pkg::sat32(wy);
        end
    end

    // P2: half size times ndc
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg     <= $signed({1'b0, half_w}) * ndc_x_reg;
            py_reg     <= $signed({1'b0, half_h}) * ndc_y_reg;
            ndc_x2_reg <= ndc_x_reg;
            ndc_y2_reg <= ndc_y_reg;
            hw_reg     <= half_w;
            hh_reg     <= half_h;
        end
    end

    // P3: window mapping, y flipped
    logic signed [W-1:0] sum_x, sum_y;
    assign sum_x = W'(px_reg) + W'(ndc_x2_reg) + $signed(W'(hw_reg) << FRAC_BITS);
    assign sum_y = -W'(py_reg) + W'(ndc_y2_reg) + $signed(W'(hh_reg) << FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= s2_reg.visible ? ppp_pkg::sat32(sum_x) : '0;
            sy_reg <= s2_reg.visible ? ppp_pkg::sat32(sum_y) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg      <= '0;
            s2_reg      <= '0;
            valid_reg   <= 1'b0;
            visible_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_reg      <= side_in;
            s2_reg      <= s1_reg;
            valid_reg   <= s2_reg.valid;
            visible_reg <= s2_reg.visible;
        end
    end

    assign out_valid   = valid_reg;
    assign out_visible = visible_reg;
    assign screen_x    = sx_reg;
    assign screen_y    = sy_reg;

endmodule
